// ===== hdl/ges_pkg.sv =====
// Shared types and constants for the graph edge store.
// Used by the channel interfaces, the RAM wrapper's users, the sequencer and the top level.
`default_nettype none

package ges_pkg;

    localparam int NODE_W    = 6;
    localparam int DEG_W     = 7;
    localparam int NODES_DEF = 64;

    // Request opcodes.
    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // One word of the per-vertex memory.
    typedef struct packed {
        logic             active;
        logic [DEG_W-1:0] degree;
    } vert_t;

    // Status returned for every request.
    typedef struct packed {
        logic             edge_was_new;
        logic             skipped;
        logic [DEG_W-1:0] degree_a;
        logic             active_a;
    } res_t;

endpackage

`default_nettype wire

// ===== hdl/ges_cmd_if.sv =====
// Request channel of the graph edge store: valid/ready plus the request fields.
// Depends on ges_pkg for the field widths.
`default_nettype none

interface ges_cmd_if
    import ges_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;

    modport source (output valid, output action, output node_a, output node_b, input ready);
    modport sink   (input valid, input action, input node_a, input node_b, output ready);
endinterface

`default_nettype wire

// ===== hdl/ges_sts_if.sv =====
// Status channel of the graph edge store: valid/ready plus the status fields.
// Depends on ges_pkg for the field widths.
`default_nettype none

interface ges_sts_if
    import ges_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             edge_was_new;
    logic             skipped;
    logic [DEG_W-1:0] degree_a;
    logic             active_a;

    modport source (output valid, output edge_was_new, output skipped, output degree_a,
                    output active_a, input ready);
    modport sink   (input valid, input edge_was_new, input skipped, input degree_a,
                    input active_a, output ready);
endinterface

`default_nettype wire

// ===== hdl/ges_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Standalone; no package dependency.
`default_nettype none

module ges_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/ges_seq.sv =====
// Sequencer of the graph edge store: clearing pass, add-edge and remove-vertex
// read-modify-write sequences on the adjacency and vertex memories. Uses ges_pkg.
`default_nettype none

module ges_seq
    import ges_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ges_cmd_if.sink                    cmd,
    output logic [$clog2(NODES)-1:0]   raddr,
    output logic [$clog2(NODES)-1:0]   waddr,
    output logic                       adj_we,
    output logic [NODES-1:0]           adj_wdata,
    input  logic [NODES-1:0]           adj_rdata,
    output logic                       vert_we,
    output vert_t                      vert_wdata,
    input  vert_t                      vert_rdata,
    output logic                       res_valid,
    input  logic                       res_ready,
    output res_t                       res
);

    localparam int AW = $clog2(NODES);
    localparam int IW = (AW > NODE_W) ? AW : NODE_W;
    localparam logic [AW-1:0] LAST = AW'(NODES - 1);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_A1    = 3'd2;
    localparam logic [2:0] S_A2    = 3'd3;
    localparam logic [2:0] S_R1    = 3'd4;
    localparam logic [2:0] S_LOOP  = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    function automatic logic [AW-1:0] to_addr(input logic [NODE_W-1:0] n);
        logic [IW-1:0] e;
        e = IW'(n);
        return e[AW-1:0];
    endfunction

    function automatic logic in_range(input logic [NODE_W-1:0] n);
        logic [IW:0] e;
        e = (IW+1)'(n);
        return e < (IW+1)'(NODES);
    endfunction

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic              p_vld_reg, p_vld_next;
    logic [AW-1:0]     p_idx_reg, p_idx_next;
    logic [NODE_W-1:0] a_reg, a_next;
    logic [NODE_W-1:0] b_reg, b_next;
    logic [NODES-1:0]  row_v_reg, row_v_next;
    res_t              res_reg, res_next;

    logic [AW-1:0]     a_addr, b_addr;
    logic              a_ok, b_ok;
    logic [NODES-1:0]  a_bit, b_bit;
    logic              add_new;
    logic [DEG_W-1:0]  deg_inc, deg_dec;

    assign a_addr  = to_addr(a_reg);
    assign b_addr  = to_addr(b_reg);
    assign a_ok    = in_range(a_reg);
    assign b_ok    = in_range(b_reg);
    assign a_bit   = NODES'(1) << a_addr;
    assign b_bit   = NODES'(1) << b_addr;
    assign add_new = a_ok && b_ok && !adj_rdata[b_addr];
    assign deg_inc = vert_rdata.degree + DEG_W'(1);
    assign deg_dec = (vert_rdata.degree != '0) ? vert_rdata.degree - DEG_W'(1) : '0;
    assign res     = res_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        p_vld_next = 1'b0;
        p_idx_next = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        row_v_next = row_v_reg;
        res_next   = res_reg;
        raddr      = cnt_reg;
        waddr      = cnt_reg;
        adj_we     = 1'b0;
        adj_wdata  = '0;
        vert_we    = 1'b0;
        vert_wdata = '0;
        cmd.ready  = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            S_CLR:
            begin
                adj_we   = 1'b1;
                vert_we  = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                // The read of node_a is launched on the accepting edge itself.
                cmd.ready = 1'b1;
                raddr     = to_addr(cmd.node_a);
                if (cmd.valid)
                begin
                    a_next     = cmd.node_a;
                    b_next     = cmd.node_b;
                    state_next = (cmd.action == ACT_REMOVE) ? S_R1 : S_A1;
                end
            end
            S_A1:
            begin
                if (add_new)
                begin
                    waddr                 = a_addr;
                    adj_we                = 1'b1;
                    adj_wdata             = adj_rdata | b_bit;
                    vert_we               = 1'b1;
                    vert_wdata.active     = 1'b1;
                    vert_wdata.degree     = deg_inc;
                    raddr                 = b_addr;
                    res_next.edge_was_new = 1'b1;
                    res_next.skipped      = 1'b0;
                    res_next.degree_a     = deg_inc;
                    res_next.active_a     = 1'b1;
                    // A self-loop touches a single row and a single degree.
                    state_next = (a_addr == b_addr) ? S_DONE : S_A2;
                end
                else
                begin
                    res_next.edge_was_new = 1'b0;
                    res_next.skipped      = 1'b0;
                    res_next.degree_a     = a_ok ? vert_rdata.degree : '0;
                    res_next.active_a     = a_ok && vert_rdata.active;
                    state_next            = S_DONE;
                end
            end
            S_A2:
            begin
                waddr             = b_addr;
                adj_we            = 1'b1;
                adj_wdata         = adj_rdata | a_bit;
                vert_we           = 1'b1;
                vert_wdata.active = 1'b1;
                vert_wdata.degree = deg_inc;
                state_next        = S_DONE;
            end
            S_R1:
            begin
                if (a_ok && vert_rdata.active)
                begin
                    // Clear the vertex's own row and word now, then sweep the neighbors.
                    waddr      = a_addr;
                    adj_we     = 1'b1;
                    vert_we    = 1'b1;
                    row_v_next = adj_rdata;
                    res_next   = '0;
                    cnt_next   = '0;
                    state_next = S_LOOP;
                end
                else
                begin
                    res_next.edge_was_new = 1'b0;
                    res_next.skipped      = 1'b1;
                    res_next.degree_a     = a_ok ? vert_rdata.degree : '0;
                    res_next.active_a     = a_ok && vert_rdata.active;
                    state_next            = S_DONE;
                end
            end
            S_LOOP:
            begin
                raddr      = cnt_reg;
                p_vld_next = 1'b1;
                p_idx_next = cnt_reg;
                cnt_next   = cnt_reg + AW'(1);
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Write-back half of the neighbor sweep: the row whose read was launched in the cycle
        // before loses its bit for the removed vertex, and the neighbor's degree drops by one.
        if (p_vld_reg)
        begin
            waddr             = p_idx_reg;
            adj_we            = row_v_reg[p_idx_reg];
            adj_wdata         = adj_rdata & ~a_bit;
            vert_we           = row_v_reg[p_idx_reg];
            vert_wdata.degree = deg_dec;
            vert_wdata.active = vert_rdata.active && (deg_dec != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
            p_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            p_vld_reg <= p_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg <= p_idx_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        row_v_reg <= row_v_next;
        res_reg   <= res_next;
    end

    a_sweep_in_removal: assert property (@(posedge clk) disable iff (!rst_n)
        p_vld_reg |-> (state_reg == S_LOOP || state_reg == S_DRAIN))
        else $error("neighbor write-back outside a removal sweep");

    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("pending status changed before it was taken");

    a_new_edge_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A1 && add_new) |=> (res_reg.active_a && res_reg.edge_was_new))
        else $error("new edge did not report an active endpoint");

    a_removed_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |=>
            (state_reg == S_DONE && res_reg.degree_a == '0 && !res_reg.active_a))
        else $error("removed vertex not reported as cleared");

endmodule

`default_nettype wire

// ===== hdl/graph_edge_store_with_degrees.sv =====
// Graph edge store with vertex degrees: top level with the two memories, the sequencer
// and the status output register. Depends on ges_pkg, ges_cmd_if, ges_sts_if, ges_ram, ges_seq.
//
// Usage:
//   cmd carries requests (action, node_a, node_b) with valid/ready; status returns one
//   result (edge_was_new, skipped, degree_a, active_a) per request, in order.
//   After reset the block runs a clearing pass over every address of both memories;
//   cmd.ready stays low until it finishes. An add-edge request passes from acceptance
//   through S_A1 and S_A2 to S_DONE, where its status is loaded into the output register
//   (S_A2 is left out for a self-loop, a present edge or an out-of-range node).
//   A remove-vertex request on an active vertex clears its own row and word, then the
//   sequencer sweeps every vertex, one read-modify-write per cycle on the adjacency
//   memory and the degree memory, pipelined over their registered read data. A skipped
//   removal goes straight to S_DONE. The next request can be accepted in the cycle
//   after the status is loaded. One request is in work at a time. The output register
//   holds a finished status while status.ready is low; the next request is accepted
//   meanwhile, and its status waits in the sequencer until the output register frees up.
`default_nettype none

module graph_edge_store_with_degrees
    import ges_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ges_cmd_if.sink    cmd,
    ges_sts_if.source  status
);

    localparam int AW = $clog2(NODES);

    logic [AW-1:0]    raddr;
    logic [AW-1:0]    waddr;
    logic             adj_we;
    logic [NODES-1:0] adj_wdata;
    logic [NODES-1:0] adj_rdata;
    logic             vert_we;
    vert_t            vert_wdata;
    vert_t            vert_rdata;
    logic             res_valid;
    logic             res_ready;
    res_t             res;

    logic             out_valid_reg, out_valid_next;
    res_t             out_reg;

    ges_ram #(
        .W (NODES),
        .D (NODES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (waddr),
        .wdata (adj_wdata),
        .raddr (raddr),
        .rdata (adj_rdata)
    );

    ges_ram #(
        .W ($bits(vert_t)),
        .D (NODES)
    ) u_vert_ram (
        .clk   (clk),
        .we    (vert_we),
        .waddr (waddr),
        .wdata (vert_wdata),
        .raddr (raddr),
        .rdata (vert_rdata)
    );

    ges_seq #(
        .NODES (NODES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .raddr      (raddr),
        .waddr      (waddr),
        .adj_we     (adj_we),
        .adj_wdata  (adj_wdata),
        .adj_rdata  (adj_rdata),
        .vert_we    (vert_we),
        .vert_wdata (vert_wdata),
        .vert_rdata (vert_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !out_valid_reg || status.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign status.valid        = out_valid_reg;
    assign status.edge_was_new = out_reg.edge_was_new;
    assign status.skipped      = out_reg.skipped;
    assign status.degree_a     = out_reg.degree_a;
    assign status.active_a     = out_reg.active_a;

endmodule

`default_nettype wire
